// ===== hdl/vsf_pkg.sv =====
// Shared types and constants for the viewport scale-fit core.
// Used by vsf_prep, vsf_div_cell, the top level and the bench; depends on nothing else.
`default_nettype none
package vsf_pkg;

	// Field widths of a request and a result.
	localparam int DIM_W  = 14;
	localparam int OFF_W  = 13;
	localparam int MODE_W = 2;
	localparam int PROD_W = 2 * DIM_W;

	// One divider cell per quotient bit.
	localparam int DIV_CELLS = DIM_W;

	// Scaling mode selector carried on the request's tuser.
	typedef enum logic [MODE_W-1:0] {
		MODE_ASPECT     = 2'd0,
		MODE_FULL       = 2'd1,
		MODE_CENTER     = 2'd2,
		MODE_ASPECT_ALT = 2'd3
	} mode_t;

	// How the final stage completes a result.
	typedef enum logic [1:0] {
		KIND_DIRECT = 2'd0,
		KIND_FIT_H  = 2'd1,
		KIND_FIT_W  = 2'd2
	} kind_t;

	// Unpacked request fields.
	typedef struct packed {
		logic [DIM_W-1:0] rw;
		logic [DIM_W-1:0] rh;
		logic [DIM_W-1:0] sw;
		logic [DIM_W-1:0] sh;
		mode_t            mode;
	} req_t;

	// Result under construction. For the fit kinds, w and h hold the raster size.
	typedef struct packed {
		kind_t            kind;
		logic [OFF_W-1:0] x;
		logic [OFF_W-1:0] y;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic             zero;
	} res_t;

	// Divider state handed from cell to cell.
	typedef struct packed {
		logic [DIM_W-1:0] rem;
		logic [DIM_W-1:0] dvd_lo;
		logic [DIM_W-1:0] divisor;
		logic [DIM_W-1:0] quo;
	} div_t;

endpackage
`default_nettype wire

// ===== hdl/vsf_prep.sv =====
// Front stages: the two cross products, the aspect compare and the direct modes.
// Depends on vsf_pkg; feeds the first divider cell.
`default_nettype none
module vsf_prep import vsf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire req_t in_req,
	output logic      out_valid,
	output res_t      out_res,
	output div_t      out_div
);

	logic              valid_s1;
	req_t              req_s1;
	logic [PROD_W-1:0] prod_a_s1;
	logic [PROD_W-1:0] prod_b_s1;

	logic              valid_s2;
	res_t              res_s2;
	div_t              div_s2;

	res_t              res_d;
	div_t              div_d;
	logic              zero_src;
	logic              fit_h;
	logic [PROD_W-1:0] dividend;
	logic [DIM_W-1:0]  diff_w;
	logic [DIM_W-1:0]  diff_h;

	// Control of the two stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: raster_width * source_height and raster_height * source_width.
	always_ff @(posedge clk) begin
		if (en) begin
			req_s1    <= in_req;
			prod_a_s1 <= PROD_W'(in_req.rw) * PROD_W'(in_req.sh);
			prod_b_s1 <= PROD_W'(in_req.rh) * PROD_W'(in_req.sw);
		end
	end

	// Stage 2: pick the scaled axis and settle the modes that need no division.
	always_comb begin
		zero_src = (req_s1.sw == '0) || (req_s1.sh == '0);
		fit_h    = prod_a_s1 < prod_b_s1;
		dividend = fit_h ? prod_a_s1 : prod_b_s1;
		diff_w   = req_s1.rw - req_s1.sw;
		diff_h   = req_s1.rh - req_s1.sh;

		res_d.kind = KIND_DIRECT;
		res_d.x    = '0;
		res_d.y    = '0;
		res_d.w    = req_s1.rw;
		res_d.h    = req_s1.rh;
		res_d.zero = 1'b0;

		unique case (req_s1.mode)
			MODE_FULL: begin
			end
			MODE_CENTER: begin
				if (req_s1.rw >= req_s1.sw) begin
					res_d.w = req_s1.sw;
					res_d.x = diff_w[DIM_W-1:1];
				end
				if (req_s1.rh >= req_s1.sh) begin
					res_d.h = req_s1.sh;
					res_d.y = diff_h[DIM_W-1:1];
				end
			end
			MODE_ASPECT, MODE_ASPECT_ALT: begin
				if (zero_src) begin
					res_d.zero = 1'b1;
				end else begin
					res_d.kind = fit_h ? KIND_FIT_H : KIND_FIT_W;
				end
			end
		endcase

		// The quotient never exceeds the raster, so the high half is already
		// below the divisor and serves as the first partial remainder.
		div_d.rem     = dividend[PROD_W-1:DIM_W];
		div_d.dvd_lo  = dividend[DIM_W-1:0];
		div_d.divisor = fit_h ? req_s1.sw : req_s1.sh;
		div_d.quo     = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= res_d;
			div_s2 <= div_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_res   = res_s2;
	assign out_div   = div_s2;

endmodule
`default_nettype wire

// ===== hdl/vsf_div_cell.sv =====
// One cell of the restoring divider chain: yields one quotient bit per pass.
// Depends on vsf_pkg; instantiated in a row by the top level.
`default_nettype none
module vsf_div_cell import vsf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire res_t in_res,
	input  wire div_t in_div,
	output logic      out_valid,
	output res_t      out_res,
	output div_t      out_div
);

	logic             valid_q;
	res_t             res_q;
	div_t             div_q;

	div_t             div_d;
	logic [DIM_W:0]   trial;
	logic [DIM_W:0]   diff;
	logic             take;

	// Bring down the next dividend bit and subtract the divisor if it fits.
	always_comb begin
		trial = {in_div.rem, in_div.dvd_lo[DIM_W-1]};
		diff  = trial - {1'b0, in_div.divisor};
		take  = trial >= {1'b0, in_div.divisor};

		div_d.rem     = take ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
		div_d.dvd_lo  = {in_div.dvd_lo[DIM_W-2:0], 1'b0};
		div_d.divisor = in_div.divisor;
		div_d.quo     = {in_div.quo[DIM_W-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= in_res;
			div_q <= div_d;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;
	assign out_div   = div_q;

endmodule
`default_nettype wire

// ===== hdl/viewport_scale_fit_core.sv =====
// A request passes through vsf_prep, the 14-cell divider chain and the output register.
// Throughput: one request per cycle while the output is not stalled; a stall holds the whole chain.
// An input skid register holds one request while the output is stalled.
// Reset: arst_n clears all valid flags at once; the block takes requests right after.
// Top level of the viewport scale-fit core; depends on vsf_pkg, vsf_prep, vsf_div_cell.
`default_nettype none
module viewport_scale_fit_core import vsf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// raster_width, raster_height, source_width, source_height
	input  wire logic [55:0] s_tdata,
	// mode
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// out_x, out_y, out_width, out_height, then two zero bits
	output logic [55:0]      m_tdata,
	// zero_source
	output logic [0:0]       m_tuser
);

	logic   en;
	logic   take;
	req_t   in_req;
	logic   skid_valid_q;
	req_t   skid_req_q;
	logic   pipe_valid;
	req_t   pipe_req;

	logic   cell_valid [0:DIV_CELLS];
	res_t   cell_res   [0:DIV_CELLS];
	div_t   cell_div   [0:DIV_CELLS];

	res_t   fin_d;
	logic [DIM_W-1:0] quo;
	logic [DIM_W-1:0] gap;
	logic   out_valid_q;
	res_t   out_res_q;

	// Request unpacking.
	assign in_req.rw   = s_tdata[13:0];
	assign in_req.rh   = s_tdata[27:14];
	assign in_req.sw   = s_tdata[41:28];
	assign in_req.sh   = s_tdata[55:42];
	assign in_req.mode = mode_t'(s_tuser);

	// The whole pipeline moves whenever the output register can take a result.
	assign en       = !out_valid_q || m_tready;
	assign s_tready = !skid_valid_q;
	assign take     = s_tvalid && s_tready;

	// Skid register: catches a request that arrives while the pipeline is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (en) begin
			skid_valid_q <= 1'b0;
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && take) begin
			skid_req_q <= in_req;
		end
	end

	assign pipe_valid = skid_valid_q || take;
	assign pipe_req   = skid_valid_q ? skid_req_q : in_req;

	vsf_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pipe_valid),
		.in_req    (pipe_req),
		.out_valid (cell_valid[0]),
		.out_res   (cell_res[0]),
		.out_div   (cell_div[0])
	);

	// Divider chain, one quotient bit per cell from the top down.
	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
		vsf_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cell_valid[i]),
			.in_res    (cell_res[i]),
			.in_div    (cell_div[i]),
			.out_valid (cell_valid[i+1]),
			.out_res   (cell_res[i+1]),
			.out_div   (cell_div[i+1])
		);
	end

	// Place the scaled axis and center it in the raster.
	always_comb begin
		quo   = cell_div[DIV_CELLS].quo;
		fin_d = cell_res[DIV_CELLS];
		gap   = '0;
		unique case (cell_res[DIV_CELLS].kind)
			KIND_FIT_H: begin
				gap     = cell_res[DIV_CELLS].h - quo;
				fin_d.h = quo;
				fin_d.y = gap[DIM_W-1:1];
			end
			KIND_FIT_W: begin
				gap     = cell_res[DIV_CELLS].w - quo;
				fin_d.w = quo;
				fin_d.x = gap[DIM_W-1:1];
			end
			default: begin
			end
		endcase
		fin_d.kind = KIND_DIRECT;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= cell_valid[DIV_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_res_q <= fin_d;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = {2'b00, out_res_q.h, out_res_q.w, out_res_q.y, out_res_q.x};
	assign m_tuser[0] = out_res_q.zero;

endmodule
`default_nettype wire

// ===== hdl/vsf_checker.sv =====
// Port-level checks for the viewport scale-fit core, bound to its top level.
// Depends only on the top level's port list.
`default_nettype none
module vsf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [55:0] s_tdata,
	input wire logic [1:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [55:0] m_tdata,
	input wire logic [0:0]  m_tuser
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// A zero-source result always sits at the raster origin.
	a_zero_origin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[25:0] == 26'd0)
		else $error("zero-source result has a nonzero offset");

	// Nothing is shown at the first edge out of reset.
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result shown right after reset");

	// The input only backs off when a request met a stalled output.
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid) && $past(m_tvalid) && !$past(m_tready))
		else $error("input ready dropped without a stalled output");

endmodule

bind viewport_scale_fit_core vsf_checker u_vsf_checker (.*);
`default_nettype wire

// ===== bench/vsf_result_checker.sv =====
// Result checker for the viewport scale-fit core: predicts each placement and compares it.
// Watches both stream channels of the core; depends on vsf_pkg for the mode encoding and field widths.
`timescale 1ns / 100ps
module vsf_result_checker import vsf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	// raster_width, raster_height, source_width, source_height
	input  wire logic [55:0] s_tdata,
	// mode
	input  wire logic [1:0]  s_tuser,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	// out_x, out_y, out_width, out_height, then two zero bits
	input  wire logic [55:0] m_tdata,
	// zero_source
	input  wire logic [0:0]  m_tuser,
	output int               mismatch_count,
	output int               awaiting_count,
	output int               results_checked,
	output int               zero_flag_count
);

	// One output viewport as the core should place it.
	typedef struct packed {
		logic [OFF_W-1:0] x;
		logic [OFF_W-1:0] y;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic             zero;
	} viewport_t;

	viewport_t placement_q[$];
	int        errors;
	int        checked;
	int        flagged;

	// Work out where the source lands inside the raster for one request.
	function automatic viewport_t fit_viewport(logic [DIM_W-1:0] rw, logic [DIM_W-1:0] rh,
			logic [DIM_W-1:0] sw, logic [DIM_W-1:0] sh, mode_t mode);
		viewport_t        vp;
		logic [PROD_W-1:0] cross_w;
		logic [PROD_W-1:0] cross_h;
		logic [PROD_W-1:0] scaled;
		logic [DIM_W-1:0]  spare;
		vp = '0;
		case (mode)
			MODE_FULL: begin
				vp.w = rw;
				vp.h = rh;
			end
			MODE_CENTER: begin
				// Each axis keeps the source size if it fits, else it is clipped to the raster.
				if (rw >= sw) begin
					spare = rw - sw;
					vp.w  = sw;
					vp.x  = spare[DIM_W-1:1];
				end else begin
					vp.w = rw;
				end
				if (rh >= sh) begin
					spare = rh - sh;
					vp.h  = sh;
					vp.y  = spare[DIM_W-1:1];
				end else begin
					vp.h = rh;
				end
			end
			default: begin
				// Aspect fit, for both MODE_ASPECT and MODE_ASPECT_ALT.
				if (sw == '0 || sh == '0) begin
					vp.w    = rw;
					vp.h    = rh;
					vp.zero = 1'b1;
				end else begin
					cross_w = rw * sh;
					cross_h = rh * sw;
					if (cross_w < cross_h) begin
						// Width-limited: full raster width, letterbox top and bottom.
						scaled = sh * rw;
						scaled = scaled / sw;
						vp.w   = rw;
						vp.h   = scaled[DIM_W-1:0];
						spare  = rh - vp.h;
						vp.y   = spare[DIM_W-1:1];
					end else begin
						// Height-limited: full raster height, pillarbox left and right.
						scaled = sw * rh;
						scaled = scaled / sh;
						vp.w   = scaled[DIM_W-1:0];
						vp.h   = rh;
						spare  = rw - vp.w;
						vp.x   = spare[DIM_W-1:1];
					end
				end
			end
		endcase
		return vp;
	endfunction

	// Queue a prediction for every accepted request and check every accepted result.
	always @(posedge clk or negedge arst_n) begin
		viewport_t want;
		viewport_t got;
		if (!arst_n) begin
			placement_q.delete();
			errors = 0;
			checked = 0;
			flagged = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				placement_q.push_back(fit_viewport(s_tdata[13:0], s_tdata[27:14],
					s_tdata[41:28], s_tdata[55:42], mode_t'(s_tuser)));
			end
			if (m_tvalid && m_tready) begin
				got.x    = m_tdata[12:0];
				got.y    = m_tdata[25:13];
				got.w    = m_tdata[39:26];
				got.h    = m_tdata[53:40];
				got.zero = m_tuser[0];
				checked++;
				if (got.zero) begin
					flagged++;
				end
				if (placement_q.size() == 0) begin
					$error("result with no request outstanding: x=%0d y=%0d w=%0d h=%0d",
						got.x, got.y, got.w, got.h);
					errors++;
				end else begin
					want = placement_q.pop_front();
					if (got.x !== want.x) begin
						$error("out_x: expected %0d, got %0d", want.x, got.x);
						errors++;
					end
					if (got.y !== want.y) begin
						$error("out_y: expected %0d, got %0d", want.y, got.y);
						errors++;
					end
					if (got.w !== want.w) begin
						$error("out_width: expected %0d, got %0d", want.w, got.w);
						errors++;
					end
					if (got.h !== want.h) begin
						$error("out_height: expected %0d, got %0d", want.h, got.h);
						errors++;
					end
					if (got.zero !== want.zero) begin
						$error("zero_source: expected %0d, got %0d", want.zero, got.zero);
						errors++;
					end
				end
			end
		end
		// Counters change only at the edge so the stimulus side reads them without a race.
		mismatch_count  <= errors;
		awaiting_count  <= placement_q.size();
		results_checked <= checked;
		zero_flag_count <= flagged;
	end

endmodule

// ===== bench/testbench.sv =====
// Top of the viewport scale-fit bench: clock, reset, request stimulus and the verdict.
// Depends on vsf_pkg, viewport_scale_fit_core and vsf_result_checker.
`timescale 1ns / 100ps
module testbench;
	import vsf_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic [0:0]  m_tuser;

	int mismatch_count;
	int awaiting_count;
	int results_checked;
	int zero_flag_count;
	int idle_cycles;
	int mode_sent [4];
	int long_hold_cycles = 0;
	bit tx_eager = 1'b0;
	bit rx_eager = 1'b0;

	viewport_scale_fit_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	vsf_result_checker result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.mismatch_count  (mismatch_count),
		.awaiting_count  (awaiting_count),
		.results_checked (results_checked),
		.zero_flag_count (zero_flag_count)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: end the run if no request or result moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("viewport_scale_fit_core verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result side: random stalls per result, eager stretches, and one long hold-off.
	initial begin : result_drain
		int stall;
		m_tready = 1'b0;
		@(posedge clk);
		forever begin
			if (long_hold_cycles > 0) begin
				stall = long_hold_cycles;
				long_hold_cycles = 0;
			end else if (rx_eager) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 16);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// Offer one request after a random gap (none when tx_eager is set) and hold it until the core takes it.
	task automatic offer_request(input logic [DIM_W-1:0] rw, input logic [DIM_W-1:0] rh,
			input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh, input mode_t mode);
		int gap;
		gap = tx_eager ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {sh, sw, rh, rw};
		s_tuser  <= mode;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		mode_sent[mode]++;
	endtask

	// Stop offering until every outstanding result has come back.
	task automatic await_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaiting_count != 0) @(posedge clk);
	endtask

	// Dimension mix: zeros, maxima, tiny values, mid range and the full range.
	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return DIM_W'($urandom_range(1, 16));
			3, 4:    return DIM_W'($urandom_range(0, 2047));
			default: return DIM_W'($urandom_range(0, 16383));
		endcase
	endfunction

	initial begin : request_source
		logic [DIM_W-1:0] rw;
		logic [DIM_W-1:0] rh;
		logic [DIM_W-1:0] sw;
		logic [DIM_W-1:0] sh;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = MODE_ASPECT;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests: extremes, every mode, zero source and zero raster, clipping.
		offer_request(16383, 16383, 16383, 16383, MODE_ASPECT);
		offer_request(16383, 16383, 16383, 16383, MODE_FULL);
		offer_request(16383, 16383, 16383, 16383, MODE_CENTER);
		offer_request(16383, 16383, 16383, 16383, MODE_ASPECT_ALT);
		offer_request(1920, 1080, 0, 480, MODE_ASPECT);
		offer_request(1920, 1080, 640, 0, MODE_ASPECT_ALT);
		offer_request(0, 0, 0, 0, MODE_ASPECT);
		offer_request(1920, 1080, 0, 0, MODE_FULL);
		offer_request(1920, 1080, 0, 0, MODE_CENTER);
		offer_request(0, 0, 100, 50, MODE_ASPECT);
		offer_request(0, 0, 100, 50, MODE_CENTER);
		offer_request(1920, 1080, 640, 480, MODE_ASPECT);
		offer_request(1920, 1080, 2560, 1080, MODE_ASPECT);
		offer_request(1920, 1080, 2560, 1080, MODE_ASPECT_ALT);
		offer_request(1920, 1080, 960, 540, MODE_ASPECT);
		offer_request(16383, 1, 1, 16383, MODE_ASPECT);
		offer_request(1, 16383, 16383, 1, MODE_ASPECT);
		offer_request(16383, 16383, 1, 1, MODE_ASPECT);
		offer_request(1921, 1081, 640, 480, MODE_CENTER);
		offer_request(640, 480, 1921, 1081, MODE_CENTER);
		offer_request(640, 1081, 1921, 480, MODE_CENTER);
		offer_request(800, 600, 800, 600, MODE_CENTER);
		offer_request(0, 0, 16383, 16383, MODE_CENTER);
		await_drain();

		// Random requests in phases with different idle behavior on each side.
		for (int phase = 0; phase < 25; phase++) begin
			tx_eager = ($urandom_range(0, 3) == 0);
			rx_eager = ($urandom_range(0, 3) == 0);
			if (phase == 4) begin
				// Back-to-back requests against a long result hold-off fill the core.
				tx_eager = 1'b1;
				rx_eager = 1'b0;
				long_hold_cycles = HOLD_CYCLES;
			end
			for (int n = 0; n < 50; n++) begin
				rw = pick_dim();
				rh = pick_dim();
				sw = pick_dim();
				sh = pick_dim();
				// Now and then the source is the raster halved on each axis, close to the raster's aspect ratio.
				if ($urandom_range(0, 7) == 0) begin
					sw = rw >> 1;
					sh = rh >> 1;
				end
				offer_request(rw, rh, sw, sh, mode_t'($urandom_range(0, 3)));
			end
			if (phase % 6 == 5) begin
				await_drain();
			end
		end

		// Let the last results through, then give the verdict.
		await_drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d aspect, %0d full, %0d centered and %0d alternate-aspect requests.",
			mode_sent[MODE_ASPECT], mode_sent[MODE_FULL], mode_sent[MODE_CENTER],
			mode_sent[MODE_ASPECT_ALT]);
		$display("Compared %0d placements, %0d of them flagged for a zero source.",
			results_checked, zero_flag_count);
		if (mismatch_count == 0 && awaiting_count == 0) begin
			$display("viewport_scale_fit_core verification clean");
		end else begin
			$display("viewport_scale_fit_core verification failed");
		end
		$finish;
	end

endmodule
